// File: rtl/core/tlbse_pkg.sv
// Package: shared types and constants for the TLB shootdown epoch tracker.
`default_nettype none

package tlbse_pkg;

    localparam int TYPE_W  = 2;
    localparam int CORE_W  = 4;
    localparam int ROOT_W  = 64;
    localparam int COUNT_W = 5;
    localparam int PHASE_W = 2;

    localparam int MAX_CORES_DEF = 16;

    typedef logic [TYPE_W-1:0]  req_type_t;
    typedef logic [CORE_W-1:0]  core_id_t;
    typedef logic [ROOT_W-1:0]  root_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [PHASE_W-1:0] core_phase_t;

    localparam req_type_t REQ_ROOT_SWITCH = 2'd0;
    localparam req_type_t REQ_IDLE_ENTER  = 2'd1;
    localparam req_type_t REQ_IDLE_EXIT   = 2'd2;
    localparam req_type_t REQ_INVALIDATE  = 2'd3;

    localparam core_phase_t PHASE_IDLE  = 2'd2;
    localparam count_t      COUNT_MAX   = 5'd31;
    localparam count_t      CORE_COUNT_RST = 5'd16;

endpackage

`default_nettype wire

// File: rtl/core/tlb_shootdown_epoch_tracker_core.sv
// Top level: TLB shootdown epoch tracker with input and result registers.
//
//   channel | ports                                              | dir
//   --------+----------------------------------------------------+-----
//   input   | s_valid s_ready s_req_type s_core_id s_old_root    | in
//           | s_new_root                                         |
//   result  | m_valid m_ready m_load_root m_root_value           | out
//           | m_acknowledged m_epoch_done m_request_accepted     |
//   config  | cfg_valid cfg_ready cfg_core_count                 | in
//
// An item's result is offered on m_valid after it passes the input register and then the
// result register, and one item is accepted every cycle while the result is not stalled;
// the per-core phase table and the counters are read and modified combinationally between
// the registers and written as the item moves into the result register.
// Reset clears the phase table to acknowledged-in-phase-0 at once; no clearing pass.
// A stalled result holds the result register; the input register then fills and
// s_ready drops until m_ready returns.
`default_nettype none

module tlb_shootdown_epoch_tracker_core #(
    parameter int MAX_CORES = tlbse_pkg::MAX_CORES_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,

    input  wire                      s_valid,
    output logic                     s_ready,
    input  tlbse_pkg::req_type_t     s_req_type,
    input  tlbse_pkg::core_id_t      s_core_id,
    input  tlbse_pkg::root_t         s_old_root,
    input  tlbse_pkg::root_t         s_new_root,

    output logic                     m_valid,
    input  wire                      m_ready,
    output logic                     m_load_root,
    output tlbse_pkg::root_t         m_root_value,
    output logic                     m_acknowledged,
    output logic                     m_epoch_done,
    output logic                     m_request_accepted,

    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  tlbse_pkg::count_t        cfg_core_count
);
    import tlbse_pkg::*;

    // core_id is 4 bits, so only the first 16 entries can ever be addressed
    localparam int ID_SPAN   = 1 << CORE_W;
    localparam int TBL_DEPTH = (MAX_CORES < ID_SPAN) ? MAX_CORES : ID_SPAN;
    localparam int CAP_INT   = (MAX_CORES < 31) ? MAX_CORES : 31;
    localparam count_t CORE_CAP = count_t'(CAP_INT);

    // input register
    logic        in_valid_reg;
    req_type_t   in_type_reg;
    core_id_t    in_core_reg;
    root_t       in_old_reg;
    root_t       in_new_reg;

    // state
    logic        phase_bit_reg;
    core_phase_t core_phase_reg [TBL_DEPTH];
    count_t      owing_count_reg, owing_count_next;
    count_t      idle_count_reg, idle_count_next;
    logic        epoch_pending_reg, epoch_pending_next;
    logic        phase_bit_next;
    count_t      core_count_reg;

    // result register
    logic        out_valid_reg;
    logic        out_load_reg;
    root_t       out_root_reg;
    logic        out_ack_reg;
    logic        out_done_reg;
    logic        out_acc_reg;

    logic        advance;
    logic        in_tbl;
    core_phase_t rd_phase;
    logic        eff_phase;
    count_t      cc_clip;
    count_t      n_load;
    count_t      owing_base;
    count_t      owing_dec;
    logic        ack_allowed;
    logic        ack_c;
    logic        done_c;
    logic        acc_c;
    logic        load_c;
    root_t       root_c;
    logic        tbl_we;
    core_phase_t tbl_wdata;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // table read: one entry selected by the item's core
    always_comb begin
        rd_phase = PHASE_IDLE;
        in_tbl   = 1'b0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (in_core_reg == core_id_t'(i)) begin
                rd_phase = core_phase_reg[i];
                in_tbl   = 1'b1;
            end
        end
    end

    always_comb begin
        acc_c      = (in_type_reg == REQ_INVALIDATE) && !epoch_pending_reg;
        // a request acks against the flipped phase
        eff_phase  = (in_type_reg == REQ_INVALIDATE) ? ~phase_bit_reg : phase_bit_reg;
        cc_clip    = (core_count_reg > CORE_CAP) ? CORE_CAP : core_count_reg;
        n_load     = (cc_clip > idle_count_reg) ? cc_clip - idle_count_reg : '0;
        owing_base = acc_c ? n_load : owing_count_reg;
        owing_dec  = (owing_base == '0) ? '0 : owing_base - 5'd1;

        ack_allowed = (in_type_reg == REQ_ROOT_SWITCH) || (in_type_reg == REQ_IDLE_ENTER)
                      || acc_c;
        ack_c  = ack_allowed && in_tbl && (rd_phase == {1'b0, eff_phase});
        done_c = ack_c && (owing_dec == '0);

        load_c = (in_type_reg == REQ_ROOT_SWITCH) && (ack_c || (in_old_reg != in_new_reg));
        root_c = (in_type_reg == REQ_ROOT_SWITCH) ? in_new_reg : '0;

        phase_bit_next     = acc_c ? ~phase_bit_reg : phase_bit_reg;
        owing_count_next   = ack_c ? owing_dec : owing_base;
        epoch_pending_next = done_c ? 1'b0 : (epoch_pending_reg || acc_c);
        idle_count_next    = idle_count_reg;
        tbl_we             = ack_c;
        tbl_wdata          = {1'b0, ~eff_phase};

        case (in_type_reg)
            REQ_IDLE_ENTER: begin
                if (idle_count_reg < COUNT_MAX) idle_count_next = idle_count_reg + 5'd1;
                tbl_we    = 1'b1;
                tbl_wdata = PHASE_IDLE;
            end
            REQ_IDLE_EXIT: begin
                if (idle_count_reg != '0) idle_count_next = idle_count_reg - 5'd1;
                tbl_we    = 1'b1;
                tbl_wdata = {1'b0, ~phase_bit_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_bit_reg     <= 1'b0;
            owing_count_reg   <= '0;
            idle_count_reg    <= '0;
            epoch_pending_reg <= 1'b0;
            core_count_reg    <= CORE_COUNT_RST;
            for (int i = 0; i < TBL_DEPTH; i++) begin
                core_phase_reg[i] <= 2'd1;
            end
        end else begin
            if (cfg_valid && cfg_ready) core_count_reg <= cfg_core_count;

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                phase_bit_reg     <= phase_bit_next;
                owing_count_reg   <= owing_count_next;
                idle_count_reg    <= idle_count_next;
                epoch_pending_reg <= epoch_pending_next;
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (tbl_we && in_core_reg == core_id_t'(i)) core_phase_reg[i] <= tbl_wdata;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg <= s_req_type;
            in_core_reg <= s_core_id;
            in_old_reg  <= s_old_root;
            in_new_reg  <= s_new_root;
        end
        if (advance) begin
            out_load_reg <= load_c;
            out_root_reg <= root_c;
            out_ack_reg  <= ack_c;
            out_done_reg <= done_c;
            out_acc_reg  <= acc_c;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_load_root        = out_load_reg;
    assign m_root_value       = out_root_reg;
    assign m_acknowledged     = out_ack_reg;
    assign m_epoch_done       = out_done_reg;
    assign m_request_accepted = out_acc_reg;

    a_owing_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        owing_count_reg <= CORE_CAP)
        else $error("owing count above core cap");

    a_idle_no_owing: assert property (@(posedge aclk) disable iff (!aresetn)
        !epoch_pending_reg |-> owing_count_reg == '0)
        else $error("cores owing with no epoch pending");

    a_done_acked: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_done_reg |-> out_ack_reg)
        else $error("epoch done without acknowledgement");

    a_accept_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && acc_c && !done_c |=> epoch_pending_reg)
        else $error("accepted request left no epoch pending");

    a_repeat_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_type_reg == REQ_INVALIDATE) && epoch_pending_reg
        |=> $stable(phase_bit_reg) && $stable(owing_count_reg))
        else $error("repeated request changed epoch state");

endmodule

`default_nettype wire
